// File: hw/rtl/assert_macros.svh
// Assertion macros used by the checker RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define MCIC_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition must never be seen at a clock edge outside reset.
`define MCIC_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// File: hw/rtl/mcic_pkg.sv
// Types and constants of the microcode image checker.
package mcic_pkg;

	localparam int unsigned WORD_W = 32;
	localparam int unsigned IDX_W = 30;
	localparam int unsigned PLAT_W = 3;
	localparam int unsigned CFG_IDX_W = 1;
	localparam int unsigned LEN_W = IDX_W + 1;

	// Header layout, in words
	localparam int unsigned HDR_WORDS = 12;
	localparam int unsigned DEFAULT_WORDS = 512;
	localparam int unsigned EXT_HDR_BYTES = 48;
	localparam int unsigned EXT_ENTRY_OFFSET = 5;

	localparam logic [IDX_W-1:0] W_VERSION = IDX_W'(0);
	localparam logic [IDX_W-1:0] W_REVISION = IDX_W'(1);
	localparam logic [IDX_W-1:0] W_SIGNATURE = IDX_W'(3);
	localparam logic [IDX_W-1:0] W_FLAGS = IDX_W'(6);
	localparam logic [IDX_W-1:0] W_PAYLOAD = IDX_W'(7);
	localparam logic [IDX_W-1:0] W_TOTAL = IDX_W'(8);
	localparam logic [IDX_W-1:0] W_HDR_LAST = IDX_W'(HDR_WORDS - 1);
	localparam logic [IDX_W-1:0] W_HDR_END = IDX_W'(HDR_WORDS);

	localparam logic [WORD_W-1:0] HDR_VERSION_1 = WORD_W'(1);

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CPU_SIGNATURE = 1'b0,
		CFG_PLATFORM_INDEX = 1'b1
	} cfg_index_t;

	typedef enum logic [1:0] {
		MATCH_NONE = 2'd0,
		MATCH_PRIMARY = 2'd1,
		MATCH_EXTENDED = 2'd2
	} match_kind_t;

	// Verdict of one image
	typedef struct packed {
		logic version_ok;
		match_kind_t match_kind;
		logic checksum_ok;
		logic malformed;
		logic [WORD_W-1:0] ucode_revision;
	} result_t;

endpackage

// File: hw/rtl/microcode_image_checker_core.sv
// Top level of the microcode image checker.
//
//  channel  | direction | payload                                  | transfer
//  ---------+-----------+------------------------------------------+------------------------
//  in       | in        | image_word, start_image                  | in_valid & !in_stall
//  out      | out       | version_ok, match_kind, checksum_ok,     | out_valid & !out_stall
//           |           | malformed, ucode_revision                |
//  cfg      | in        | cfg_index, cfg_data                      | cfg_we
//
// One word per cycle while the result register is not stalled; a verdict passes the input stage and result register.
// Throughput is set by the single input stage feeding the scan logic and result register.
// Reset clears all image state; words after reset without a start mark form a new image.
// A stalled result holds the input stage, which then stalls the input channel.
module microcode_image_checker_core (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic [mcic_pkg::WORD_W-1:0] image_word,
	input logic start_image,
	output logic out_valid,
	input logic out_stall,
	output logic version_ok,
	output logic [1:0] match_kind,
	output logic checksum_ok,
	output logic malformed,
	output logic [mcic_pkg::WORD_W-1:0] ucode_revision,
	input logic cfg_we,
	input logic [mcic_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [mcic_pkg::WORD_W-1:0] cfg_data
);
	import mcic_pkg::*;

	logic [WORD_W-1:0] cpu_sig_q;
	logic [PLAT_W-1:0] plat_idx_q;
	logic valid_s1;
	logic [WORD_W-1:0] word_s1;
	logic start_s1;
	logic ready;
	logic fire;
	logic res_valid;
	result_t res;
	result_t res_q;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cpu_sig_q <= '0;
			plat_idx_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_CPU_SIGNATURE: cpu_sig_q <= cfg_data;
				CFG_PLATFORM_INDEX: plat_idx_q <= cfg_data[PLAT_W-1:0];
				default: ;
			endcase
		end
	end

	// Input stage
	assign fire = valid_s1 && ready;
	assign in_stall = valid_s1 && !ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			word_s1 <= image_word;
			start_s1 <= start_image;
		end
	end

	mcic_scan u_scan (
		.clk(clk),
		.arst_n(arst_n),
		.fire(fire),
		.word(word_s1),
		.start(start_s1),
		.cpu_sig(cpu_sig_q),
		.plat_idx(plat_idx_q),
		.res_valid(res_valid),
		.res(res)
	);

	mcic_out_reg u_out_reg (
		.clk(clk),
		.arst_n(arst_n),
		.res_valid(res_valid),
		.res(res),
		.out_stall(out_stall),
		.out_valid(out_valid),
		.res_q(res_q),
		.ready(ready)
	);

	assign version_ok = res_q.version_ok;
	assign match_kind = res_q.match_kind;
	assign checksum_ok = res_q.checksum_ok;
	assign malformed = res_q.malformed;
	assign ucode_revision = res_q.ucode_revision;

endmodule

// File: hw/rtl/mcic_scan.sv
// Per-word image scan: header capture, extended table search, checksum, verdict.
`include "assert_macros.svh"

module mcic_scan (
	input logic clk,
	input logic arst_n,
	input logic fire,
	input logic [mcic_pkg::WORD_W-1:0] word,
	input logic start,
	input logic [mcic_pkg::WORD_W-1:0] cpu_sig,
	input logic [mcic_pkg::PLAT_W-1:0] plat_idx,
	output logic res_valid,
	output mcic_pkg::result_t res
);
	import mcic_pkg::*;

	typedef enum logic [1:0] {PH_SIG, PH_FLAGS, PH_CSUM, PH_DONE} phase_t;

	// Image state
	logic [IDX_W-1:0] idx_q, idx_n;
	logic [WORD_W-1:0] sum_q, sum_n;
	logic [WORD_W-1:0] version_q, version_n;
	logic [WORD_W-1:0] revision_q, revision_n;
	logic [WORD_W-1:0] hdr_sig_q, hdr_sig_n;
	logic [WORD_W-1:0] hdr_flags_q, hdr_flags_n;
	logic [WORD_W-1:0] payload_q, payload_n;
	logic [WORD_W-1:0] image_q, image_n;
	logic [WORD_W-1:0] ext_count_q, ext_count_n;
	logic [WORD_W-1:0] ext_seen_q, ext_seen_n;
	logic [WORD_W-1:0] pend_sig_q, pend_sig_n;
	logic ext_match_q, ext_match_n;
	phase_t phase_q, phase_n;

	// Values derived from the size words, settled well before word 11
	logic ext_present_q;
	logic [LEN_W-1:0] ext_at_q;
	logic [LEN_W-1:0] entry_at_q;
	logic [LEN_W-1:0] len_q;
	logic short_q;
	logic [LEN_W-1:0] len_d;

	// Step logic
	logic [IDX_W-1:0] base_idx;
	logic [WORD_W-1:0] base_sum;
	logic [WORD_W-1:0] base_seen;
	phase_t base_phase;
	logic active;
	logic seen_lt;
	logic at_last;
	logic short_hit;
	logic vok;
	logic hdr_hit;

	always_comb begin
		// A start word drops whatever image was in progress
		base_idx = start ? '0 : idx_q;
		base_sum = start ? '0 : sum_q;
		base_seen = start ? '0 : ext_seen_q;
		base_phase = start ? PH_SIG : phase_q;
		active = fire && (base_phase != PH_DONE);

		idx_n = idx_q;
		sum_n = sum_q;
		version_n = version_q;
		revision_n = revision_q;
		hdr_sig_n = hdr_sig_q;
		hdr_flags_n = hdr_flags_q;
		payload_n = payload_q;
		image_n = image_q;
		ext_count_n = ext_count_q;
		ext_seen_n = ext_seen_q;
		pend_sig_n = pend_sig_q;
		ext_match_n = ext_match_q;
		phase_n = phase_q;
		seen_lt = base_seen < ext_count_q;
		at_last = 1'b0;
		short_hit = 1'b0;

		if (fire && start) begin
			idx_n = '0;
			sum_n = '0;
			ext_count_n = '0;
			ext_seen_n = '0;
			ext_match_n = 1'b0;
			phase_n = PH_SIG;
		end

		if (active) begin
			sum_n = base_sum + word;
			idx_n = base_idx + IDX_W'(1);

			// Header words
			case (base_idx)
				W_VERSION: version_n = word;
				W_REVISION: revision_n = word;
				W_SIGNATURE: hdr_sig_n = word;
				W_FLAGS: hdr_flags_n = word;
				W_PAYLOAD: payload_n = word;
				W_TOTAL: image_n = word;
				default: ;
			endcase

			// Extended signature table
			if (base_idx >= W_HDR_END && ext_present_q) begin
				if ({1'b0, base_idx} == ext_at_q) begin
					ext_count_n = word;
				end else if ({1'b0, base_idx} >= entry_at_q) begin
					case (base_phase)
						PH_SIG: begin
							pend_sig_n = word;
							phase_n = PH_FLAGS;
						end
						PH_FLAGS: begin
							if (seen_lt && pend_sig_q == cpu_sig && word[{2'b00, plat_idx}])
								ext_match_n = 1'b1;
							if (seen_lt)
								ext_seen_n = base_seen + WORD_W'(1);
							phase_n = PH_CSUM;
						end
						default: phase_n = PH_SIG;
					endcase
				end
			end

			// Verdict
			short_hit = (base_idx == W_HDR_LAST) && short_q;
			at_last = (base_idx >= W_HDR_LAST) && (({1'b0, base_idx} + LEN_W'(1)) == len_q);
			if (short_hit || at_last)
				phase_n = PH_DONE;
		end
	end

	assign vok = version_n == HDR_VERSION_1;
	assign hdr_hit = (hdr_sig_q == cpu_sig) && hdr_flags_q[{2'b00, plat_idx}];
	assign res_valid = short_hit || at_last;

	always_comb begin
		res.version_ok = vok;
		res.ucode_revision = revision_n;
		if (short_hit) begin
			res.match_kind = MATCH_NONE;
			res.checksum_ok = 1'b0;
			res.malformed = 1'b1;
		end else begin
			if (!vok)
				res.match_kind = MATCH_NONE;
			else if (hdr_hit)
				res.match_kind = MATCH_PRIMARY;
			else if (ext_match_n)
				res.match_kind = MATCH_EXTENDED;
			else
				res.match_kind = MATCH_NONE;
			res.checksum_ok = sum_n == '0;
			res.malformed = 1'b0;
		end
	end

	// Image state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			sum_q <= '0;
			version_q <= '0;
			revision_q <= '0;
			hdr_sig_q <= '0;
			hdr_flags_q <= '0;
			payload_q <= '0;
			image_q <= '0;
			ext_count_q <= '0;
			ext_seen_q <= '0;
			pend_sig_q <= '0;
			ext_match_q <= 1'b0;
			phase_q <= PH_SIG;
		end else begin
			idx_q <= idx_n;
			sum_q <= sum_n;
			version_q <= version_n;
			revision_q <= revision_n;
			hdr_sig_q <= hdr_sig_n;
			hdr_flags_q <= hdr_flags_n;
			payload_q <= payload_n;
			image_q <= image_n;
			ext_count_q <= ext_count_n;
			ext_seen_q <= ext_seen_n;
			pend_sig_q <= pend_sig_n;
			ext_match_q <= ext_match_n;
			phase_q <= phase_n;
		end
	end

	// Length and table position from the size words
	assign len_d = (payload_q != '0) ? {1'b0, image_q[WORD_W-1:2]} : LEN_W'(DEFAULT_WORDS);

	always_ff @(posedge clk) begin
		ext_present_q <= (payload_q != '0) &&
			({1'b0, image_q} > ({1'b0, payload_q} + (WORD_W + 1)'(EXT_HDR_BYTES)));
		ext_at_q <= {1'b0, payload_q[WORD_W-1:2]} + LEN_W'(HDR_WORDS);
		entry_at_q <= {1'b0, payload_q[WORD_W-1:2]} + LEN_W'(HDR_WORDS + EXT_ENTRY_OFFSET);
		len_q <= len_d;
		short_q <= len_d < LEN_W'(HDR_WORDS);
	end

	`MCIC_ASSERT(a_verdict_closes, clk, arst_n, res_valid |=> phase_q == PH_DONE, "image open")
	`MCIC_NEVER(a_no_result_after_done, clk, arst_n, fire && !start && phase_q == PH_DONE && res_valid, "late")
	`MCIC_ASSERT(a_malformed_clean, clk, arst_n, res_valid && res.malformed |-> res.match_kind == MATCH_NONE && !res.checksum_ok, "bad")

endmodule

// File: hw/rtl/mcic_out_reg.sv
// Result register on the output channel.
module mcic_out_reg (
	input logic clk,
	input logic arst_n,
	input logic res_valid,
	input mcic_pkg::result_t res,
	input logic out_stall,
	output logic out_valid,
	output mcic_pkg::result_t res_q,
	output logic ready
);
	import mcic_pkg::*;

	logic valid_q;

	// Slot can load when empty or when its result transfers this cycle
	assign ready = !valid_q || !out_stall;
	assign out_valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ready) begin
			valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready && res_valid)
			res_q <= res;
	end

endmodule
